// ----- hdl/ppta_pkg.sv -----
// ----------------------------------------------------------------------------
// ppta_pkg: shared types and constants for the priority token arbiter
// Sizes, null codes, operation, notice and grant codes, table write port type.
// ----------------------------------------------------------------------------
package ppta_pkg;

  localparam int unsigned NUM_CPUS  = 8;
  localparam int unsigned PRIO_BITS = 8;
  localparam int unsigned CPU_BITS  = 3;
  localparam int unsigned IDX_BITS  = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;

  typedef logic [PRIO_BITS-1:0] prio_t;
  typedef logic [IDX_BITS-1:0]  idx_t;

  // all-ones priority means no request / empty token
  localparam prio_t PRIO_NONE  = {PRIO_BITS{1'b1}};
  localparam idx_t  OWNER_NONE = '0;

  // operation codes
  localparam logic OP_REQUEST = 1'b0;
  localparam logic OP_REVOKE  = 1'b1;

  // notice kinds
  localparam logic NOTE_PAUSE  = 1'b0;
  localparam logic NOTE_RESUME = 1'b1;

  // granted flag values
  localparam logic GRANT_NO  = 1'b0;
  localparam logic GRANT_YES = 1'b1;

  // table write port
  typedef struct packed {
    logic  we;
    idx_t  addr;
    prio_t data;
  } tbl_wr_t;

endpackage

// ----- hdl/preemptive_priority_token_arbiter.sv -----
// ----------------------------------------------------------------------------
// preemptive_priority_token_arbiter: fixed-priority preemptive token arbiter
// Sequencer around one shared comparator and the per-CPU request table.
// ----------------------------------------------------------------------------
// Usage:
//   A request is accepted on a rising edge with start high and busy low.
//   operation selects request (update priority) or revoke; requester and
//   priority_req give the CPU and its priority (0 best, all ones = none).
//   Exactly one result follows per request: done is high for one cycle and
//   granted, notify_valid, notify_target and notify_kind are valid then.
//   The receiver cannot stall; each result must be taken in its cycle.
// Timing:
//   A priority request or a revoke by a non-owner: done is registered in the
//   execute step (ST_EXEC). A revoke by the current owner then walks the
//   table in ST_SCAN with the shared comparator, one entry per cycle, and
//   done is registered at the last entry. busy is high from the accept until
//   done rises; the next request can be taken at the edge that ends the done
//   cycle.
// Reset:
//   rst (synchronous) empties the table and the token; no result pending.
// ----------------------------------------------------------------------------
module preemptive_priority_token_arbiter import ppta_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic                 operation,
  input  logic [CPU_BITS-1:0]  requester,
  input  logic [PRIO_BITS-1:0] priority_req,
  output logic                 done,
  output logic                 granted,
  output logic                 notify_valid,
  output logic [CPU_BITS-1:0]  notify_target,
  output logic                 notify_kind
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_SCAN = 3'b100
  } state_t;

  state_t state;

  // latched request
  logic                item_op;
  logic [CPU_BITS-1:0] item_cpu;
  prio_t               item_prio;

  // token state
  logic  owner_valid;
  idx_t  owner_index;
  prio_t token_priority;
  idx_t  scan_idx;

  // shared datapath
  tbl_wr_t tbl_wr;
  prio_t   tbl_rd;
  prio_t   cmp_a;
  logic    cmp_lt;
  logic    in_range;
  idx_t    item_idx;
  logic    is_owner;
  logic    scan_ov_next;
  idx_t    scan_oi_next;

  assign busy     = (state != ST_IDLE);
  assign in_range = ({1'b0, item_cpu} < (CPU_BITS+1)'(NUM_CPUS));
  assign item_idx = IDX_BITS'(item_cpu);
  assign is_owner = owner_valid && (owner_index == item_idx);

  // table write happens in the execute step only
  always_comb begin
    tbl_wr.we   = (state == ST_EXEC) && in_range;
    tbl_wr.addr = item_idx;
    tbl_wr.data = (item_op == OP_REVOKE) ? PRIO_NONE : item_prio;
  end

  ppta_table u_table (
    .clk   (clk),
    .rst   (rst),
    .wr    (tbl_wr),
    .raddr (scan_idx),
    .rdata (tbl_rd)
  );

  // comparator operand: new request in execute, table entry in scan
  assign cmp_a = (state == ST_SCAN) ? tbl_rd : item_prio;

  ppta_cmp u_cmp (
    .a  (cmp_a),
    .b  (token_priority),
    .lt (cmp_lt)
  );

  // owner after the current scan step
  assign scan_ov_next = owner_valid || cmp_lt;
  assign scan_oi_next = cmp_lt ? scan_idx : owner_index;

  // sequencer and token registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      done           <= 1'b0;
      owner_valid    <= 1'b0;
      owner_index    <= OWNER_NONE;
      token_priority <= PRIO_NONE;
      scan_idx       <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (in_range && item_op == OP_REQUEST && cmp_lt) begin
            owner_valid    <= 1'b1;
            owner_index    <= item_idx;
            token_priority <= item_prio;
          end
          if (in_range && item_op == OP_REVOKE && is_owner) begin
            // owner leaves: empty the token and search for a successor
            owner_valid    <= 1'b0;
            owner_index    <= OWNER_NONE;
            token_priority <= PRIO_NONE;
            scan_idx       <= '0;
            state          <= ST_SCAN;
          end else begin
            done  <= 1'b1;
            state <= ST_IDLE;
          end
        end
        ST_SCAN: begin
          if (cmp_lt) begin
            owner_valid    <= 1'b1;
            owner_index    <= scan_idx;
            token_priority <= tbl_rd;
          end
          if (scan_idx == IDX_BITS'(NUM_CPUS - 1)) begin
            done  <= 1'b1;
            state <= ST_IDLE;
          end else begin
            scan_idx <= scan_idx + 1'b1;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start) begin
      item_op   <= operation;
      item_cpu  <= requester;
      item_prio <= priority_req;
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (state == ST_EXEC) begin
      granted       <= GRANT_NO;
      notify_valid  <= 1'b0;
      notify_target <= '0;
      notify_kind   <= NOTE_PAUSE;
      if (in_range && item_op == OP_REQUEST) begin
        granted <= (cmp_lt || is_owner) ? GRANT_YES : GRANT_NO;
        // preempted former owner gets a pause notice
        if (cmp_lt && owner_valid && owner_index != item_idx) begin
          notify_valid  <= 1'b1;
          notify_target <= CPU_BITS'(owner_index);
          notify_kind   <= NOTE_PAUSE;
        end
      end
    end else if (state == ST_SCAN && scan_idx == IDX_BITS'(NUM_CPUS - 1)) begin
      granted       <= GRANT_NO;
      notify_valid  <= scan_ov_next;
      notify_target <= scan_ov_next ? CPU_BITS'(scan_oi_next) : '0;
      notify_kind   <= scan_ov_next ? NOTE_RESUME : NOTE_PAUSE;
    end
  end

endmodule

// ----- hdl/ppta_cmp.sv -----
// ----------------------------------------------------------------------------
// ppta_cmp: shared priority comparator
// Strict less-than on two priorities, used for requests and for table scans.
// ----------------------------------------------------------------------------
module ppta_cmp import ppta_pkg::*; (
  input  prio_t a,
  input  prio_t b,
  output logic  lt
);

  // smaller value is the better priority
  assign lt = (a < b);

endmodule

// ----- hdl/ppta_table.sv -----
// ----------------------------------------------------------------------------
// ppta_table: per-CPU request priority table
// One write port, one read port; reset fills all entries with null priority.
// ----------------------------------------------------------------------------
module ppta_table import ppta_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  tbl_wr_t wr,
  input  idx_t    raddr,
  output prio_t   rdata
);

  prio_t entry [NUM_CPUS];

  // write port
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CPUS; i++) begin
        entry[i] <= PRIO_NONE;
      end
    end else if (wr.we) begin
      entry[wr.addr] <= wr.data;
    end
  end

  // read port
  assign rdata = entry[raddr];

endmodule
